### rtl/core/rrap_pkg.sv
// ----------------------------------------------------------------------------
// rrap_pkg: shared types and constants of the request array parser
// Byte codes, status and error codes, and the token record passed between
// the token unit and the parser control.
// ----------------------------------------------------------------------------
package rrap_pkg;

	// Token length limit and value widths
	localparam int unsigned INT_CHARS = 10;
	localparam int unsigned ACC_W     = 21;
	localparam int unsigned CHARS_W   = 4;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [ACC_W-1:0] LEN_CAP = ACC_W'(1048576);

	// Character codes
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Status codes
	localparam logic [1:0] ST_MORE  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	// Error kinds
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_STAR   = 3'd1;
	localparam logic [2:0] ERR_NO_DOLLAR = 3'd2;
	localparam logic [2:0] ERR_BAD_COUNT = 3'd3;
	localparam logic [2:0] ERR_BAD_LEN   = 3'd4;
	localparam logic [2:0] ERR_NO_CRLF   = 3'd5;

	// Configuration register indexes
	localparam logic REG_MAX_ARGS    = 1'b0;
	localparam logic REG_MAX_ARG_LEN = 1'b1;

	// Number token in progress
	typedef struct packed {
		logic [ACC_W-1:0]   accum;
		logic               negative;
		logic               stopped;
		logic [CHARS_W-1:0] chars;
	} tok_t;

	// One result word
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] error_kind;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] arg_index;
		logic       arg_last;
	} res_t;

endpackage

### rtl/core/rrap_token.sv
// ----------------------------------------------------------------------------
// rrap_token: number token unit
// Folds one character into a count or length token the way atoi reads it,
// with saturation, and checks the finished value against a limit.
// ----------------------------------------------------------------------------
module rrap_token (
	input  rrap_pkg::tok_t                  tok,
	input  logic [7:0]                      data_byte,
	input  logic [rrap_pkg::ACC_W-1:0]      limit,
	output logic                            take,
	output rrap_pkg::tok_t                  tok_next,
	output logic                            value_ok
);

	logic                       is_sign;
	logic                       is_digit;
	logic [3:0]                 digit;
	logic [rrap_pkg::ACC_W+3:0] prod;

	assign is_sign  = (data_byte == rrap_pkg::CH_MINUS) || (data_byte == rrap_pkg::CH_PLUS);
	assign is_digit = (data_byte >= rrap_pkg::CH_ZERO) && (data_byte <= rrap_pkg::CH_NINE);
	assign digit    = 4'(data_byte - rrap_pkg::CH_ZERO);

	// Character is part of the token while room is left
	assign take = (is_sign || is_digit) &&
		(tok.chars < rrap_pkg::CHARS_W'(rrap_pkg::INT_CHARS));

	// Multiply by ten as two shifts, then add the digit
	assign prod = ({4'd0, tok.accum} << 3) + ({4'd0, tok.accum} << 1)
		+ {{rrap_pkg::ACC_W{1'b0}}, digit};

	// Fold the character in: a leading sign sets the sign, a later one stops the value
	always_comb begin
		tok_next       = tok;
		tok_next.chars = tok.chars + rrap_pkg::CHARS_W'(1);
		if (is_sign) begin
			if (tok.chars == '0) begin
				tok_next.negative = (data_byte == rrap_pkg::CH_MINUS);
			end else begin
				tok_next.stopped = 1'b1;
			end
		end else if (!tok.stopped) begin
			if (prod > {4'd0, rrap_pkg::ACC_MAX}) begin
				tok_next.accum = rrap_pkg::ACC_MAX;
			end else begin
				tok_next.accum = prod[rrap_pkg::ACC_W-1:0];
			end
		end
	end

	assign value_ok = !tok.negative && (tok.accum != '0) && (tok.accum <= limit);

endmodule

### rtl/core/rrap_ctrl.sv
// ----------------------------------------------------------------------------
// rrap_ctrl: parser control
// Holds the parse state and the limit registers and works out the result
// word and next state for the byte in the input register.
// ----------------------------------------------------------------------------
module rrap_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [7:0]                 data_byte,
	input  logic                       start_req,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [rrap_pkg::ACC_W-1:0] wr_data,
	output rrap_pkg::res_t             res
);

	typedef enum logic [3:0] {
		PH_STAR,
		PH_COUNT,
		PH_COUNT_LF,
		PH_DOLLAR,
		PH_LEN,
		PH_LEN_LF,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF,
		PH_IDLE
	} phase_t;

	phase_t                     phase_q, phase_cur, phase_d;
	rrap_pkg::tok_t             tok_q, tok_cur, tok_d, tok_next;
	logic [7:0]                 arg_count_q, arg_count_cur, arg_count_d;
	logic [7:0]                 arg_cur_q, arg_cur_cur, arg_cur_d;
	logic [rrap_pkg::ACC_W-1:0] left_q, left_cur, left_d;
	logic [1:0]                 fin_q, fin_cur, fin_d;
	logic [2:0]                 kind_q, kind_cur, kind_d;
	logic [7:0]                 max_args_q;
	logic [rrap_pkg::ACC_W-1:0] max_len_q;
	logic [rrap_pkg::ACC_W-1:0] len_lim;
	logic [rrap_pkg::ACC_W-1:0] limit;
	logic                       take;
	logic                       value_ok;
	logic [7:0]                 arg_inc;

	// Start byte sees a freshly cleared parser
	always_comb begin
		if (start_req) begin
			phase_cur     = PH_STAR;
			tok_cur       = '0;
			arg_count_cur = '0;
			arg_cur_cur   = '0;
			left_cur      = '0;
			fin_cur       = rrap_pkg::ST_MORE;
			kind_cur      = rrap_pkg::ERR_NONE;
		end else begin
			phase_cur     = phase_q;
			tok_cur       = tok_q;
			arg_count_cur = arg_count_q;
			arg_cur_cur   = arg_cur_q;
			left_cur      = left_q;
			fin_cur       = fin_q;
			kind_cur      = kind_q;
		end
	end

	// Limit for the token being read
	assign len_lim = (max_len_q > rrap_pkg::LEN_CAP) ? rrap_pkg::LEN_CAP : max_len_q;
	assign limit   = (phase_cur == PH_COUNT) ? {13'd0, max_args_q} : len_lim;

	rrap_token u_token (
		.tok       (tok_cur),
		.data_byte (data_byte),
		.limit     (limit),
		.take      (take),
		.tok_next  (tok_next),
		.value_ok  (value_ok)
	);

	assign arg_inc = arg_cur_cur + 8'd1;

	// Next state and result word
	always_comb begin
		phase_d     = phase_cur;
		tok_d       = tok_cur;
		arg_count_d = arg_count_cur;
		arg_cur_d   = arg_cur_cur;
		left_d      = left_cur;
		fin_d       = fin_cur;
		kind_d      = kind_cur;
		res         = '0;

		if (fin_cur == rrap_pkg::ST_MORE) begin
			unique case (phase_cur)
				PH_STAR: begin
					if (data_byte == rrap_pkg::CH_STAR) begin
						tok_d   = '0;
						phase_d = PH_COUNT;
					end else begin
						fin_d   = rrap_pkg::ST_ERROR;
						kind_d  = rrap_pkg::ERR_NO_STAR;
						phase_d = PH_IDLE;
					end
				end
				PH_COUNT, PH_LEN: begin
					if (take) begin
						tok_d = tok_next;
					end else if (!value_ok) begin
						fin_d   = rrap_pkg::ST_ERROR;
						kind_d  = (phase_cur == PH_COUNT) ? rrap_pkg::ERR_BAD_COUNT
							: rrap_pkg::ERR_BAD_LEN;
						phase_d = PH_IDLE;
					end else if (data_byte != rrap_pkg::CH_CR) begin
						fin_d   = rrap_pkg::ST_ERROR;
						kind_d  = rrap_pkg::ERR_NO_CRLF;
						phase_d = PH_IDLE;
					end else if (phase_cur == PH_COUNT) begin
						arg_count_d = tok_cur.accum[7:0];
						phase_d     = PH_COUNT_LF;
					end else begin
						left_d  = tok_cur.accum;
						phase_d = PH_LEN_LF;
					end
				end
				PH_COUNT_LF: begin
					if (data_byte == rrap_pkg::CH_LF) begin
						arg_cur_d = '0;
						phase_d   = PH_DOLLAR;
					end else begin
						fin_d   = rrap_pkg::ST_ERROR;
						kind_d  = rrap_pkg::ERR_NO_CRLF;
						phase_d = PH_IDLE;
					end
				end
				PH_DOLLAR: begin
					if (data_byte == rrap_pkg::CH_DOLLAR) begin
						tok_d   = '0;
						phase_d = PH_LEN;
					end else begin
						fin_d   = rrap_pkg::ST_ERROR;
						kind_d  = rrap_pkg::ERR_NO_DOLLAR;
						phase_d = PH_IDLE;
					end
				end
				PH_LEN_LF: begin
					if (data_byte == rrap_pkg::CH_LF) begin
						phase_d = PH_DATA;
					end else begin
						fin_d   = rrap_pkg::ST_ERROR;
						kind_d  = rrap_pkg::ERR_NO_CRLF;
						phase_d = PH_IDLE;
					end
				end
				PH_DATA: begin
					res.payload_valid = 1'b1;
					res.payload_byte  = data_byte;
					res.arg_index     = arg_cur_cur;
					res.arg_last      = (left_cur <= rrap_pkg::ACC_W'(1));
					if (left_cur != '0) begin
						left_d = left_cur - rrap_pkg::ACC_W'(1);
					end
					if (left_cur <= rrap_pkg::ACC_W'(1)) begin
						phase_d = PH_DATA_CR;
					end
				end
				PH_DATA_CR: begin
					if (data_byte == rrap_pkg::CH_CR) begin
						phase_d = PH_DATA_LF;
					end else begin
						fin_d   = rrap_pkg::ST_ERROR;
						kind_d  = rrap_pkg::ERR_NO_CRLF;
						phase_d = PH_IDLE;
					end
				end
				PH_DATA_LF: begin
					if (data_byte == rrap_pkg::CH_LF) begin
						arg_cur_d = arg_inc;
						if (arg_inc >= arg_count_cur) begin
							fin_d   = rrap_pkg::ST_DONE;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_DOLLAR;
						end
					end else begin
						fin_d   = rrap_pkg::ST_ERROR;
						kind_d  = rrap_pkg::ERR_NO_CRLF;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					fin_d   = rrap_pkg::ST_ERROR;
					kind_d  = rrap_pkg::ERR_NO_STAR;
					phase_d = PH_IDLE;
				end
			endcase
		end

		res.status     = fin_d;
		res.error_kind = kind_d;
	end

	// Hold parse state; advance on each byte moved to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_STAR;
			tok_q       <= '0;
			arg_count_q <= '0;
			arg_cur_q   <= '0;
			left_q      <= '0;
			fin_q       <= rrap_pkg::ST_MORE;
			kind_q      <= rrap_pkg::ERR_NONE;
		end else if (advance) begin
			phase_q     <= phase_d;
			tok_q       <= tok_d;
			arg_count_q <= arg_count_d;
			arg_cur_q   <= arg_cur_d;
			left_q      <= left_d;
			fin_q       <= fin_d;
			kind_q      <= kind_d;
		end
	end

	// Limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= 8'd16;
			max_len_q  <= rrap_pkg::ACC_W'(512);
		end else if (wr_en) begin
			if (wr_index == rrap_pkg::REG_MAX_ARGS) begin
				max_args_q <= wr_data[7:0];
			end else begin
				max_len_q <= wr_data;
			end
		end
	end

endmodule

### rtl/core/resp_request_array_parser.sv
// ----------------------------------------------------------------------------
// resp_request_array_parser: byte-serial array request parser
// Parses '*' count CRLF followed by count bulk strings, one byte per word,
// and flags payload bytes with their argument index.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the result side is not stalled and gives one
// result word per byte. A taken byte sits in the input register, and its result
// word is loaded into the result register when the byte advances, from where it
// is offered; the parse state updates from the input register, and that loop
// sets the rate of one byte per cycle. Both registers keep moving while the
// result side stalls only as far as a slot is free. Limits are written through
// wr_en, wr_index (0: max_args, 1: max_arg_len) and wr_data while the block is
// idle.
module resp_request_array_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       start_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [2:0]                 error_kind,
	output logic                       payload_valid,
	output logic [7:0]                 payload_byte,
	output logic [7:0]                 arg_index,
	output logic                       arg_last,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [rrap_pkg::ACC_W-1:0] wr_data
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           start_s1;
	logic           valid_s2;
	rrap_pkg::res_t res_s2;
	rrap_pkg::res_t res;
	logic           advance;

	// Move a byte on when the result slot is free or being emptied
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	rrap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (byte_s1),
		.start_req (start_s1),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.res       (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			start_s1 <= start_req;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign status        = res_s2.status;
	assign error_kind    = res_s2.error_kind;
	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign arg_index     = res_s2.arg_index;
	assign arg_last      = res_s2.arg_last;

endmodule
